>>> src/msbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msbs_pkg
// Shared types, constants and the signature tables of the byte scanner.
// ----------------------------------------------------------------------------
package msbs_pkg;

   localparam int WIN_LEN    = 10;
   localparam int SIG_COUNT  = 14;
   localparam int FILL_W     = $clog2(WIN_LEN + 1);
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int OFFSET_W   = 32;
   localparam int DIST_W     = 8;

   localparam logic [DIST_W-1:0] DEDUP_RESET = 8'd16;

   typedef logic [7:0]                   byte_val_type;
   typedef logic [WIN_LEN-1:0][7:0]      window_type;
   typedef logic [SIG_COUNT-1:0]         hit_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BASE_OFFSET    = 4'd0,
      CSR_DEDUP_DISTANCE = 4'd1
   } csr_index_type;

   typedef enum logic {
      SEQ_SCAN,
      SEQ_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic test;
      logic clear;
   } dedup_ctrl_type;

   localparam logic [FILL_W-1:0] SIG_LEN [SIG_COUNT] = '{
      4'd5, 4'd8, 4'd4, 4'd2, 4'd2, 4'd2, 4'd2,
      4'd2, 4'd8, 4'd2, 4'd10, 4'd1, 4'd5, 4'd6
   };

   localparam logic [7:0] SIG_BYTE [SIG_COUNT][WIN_LEN] = '{
      '{8'hE8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h89, 8'h25, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h8B, 8'h40, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h60, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h94, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h48, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h0F, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hCD, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h31, 8'hC0, 8'h50, 8'h68, 8'h2F, 8'h2F, 8'h73, 8'h68, 8'h00, 8'h00},
      '{8'h0F, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90},
      '{8'hEB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h81, 8'hCA, 8'hFF, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hD9, 8'hEE, 8'hD9, 8'h74, 8'h24, 8'hF4, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // Bytes past a signature's length carry a zero mask; the wildcard byte of
   // the segment-register store signature is zero too.
   localparam logic [7:0] SIG_MASK [SIG_COUNT][WIN_LEN] = '{
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}
   };

endpackage : msbs_pkg
`default_nettype wire

>>> src/msbs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msbs_if
// Valid/ready stream interfaces for scanner bytes and scanner results.
// ----------------------------------------------------------------------------
interface msbs_req_if import msbs_pkg::*; ();
   logic         valid;
   logic         ready;
   byte_val_type data_byte;
   logic         last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : msbs_req_if

interface msbs_rsp_if import msbs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] start_offset;
   hit_type             hit_mask;
   logic                scan_done;

   modport source (output valid, output start_offset, output hit_mask,
                   output scan_done, input ready);
   modport sink   (input valid, input start_offset, input hit_mask,
                   input scan_done, output ready);
endinterface : msbs_rsp_if
`default_nettype wire

>>> src/masked_signature_byte_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_signature_byte_scanner
// Scans a byte stream for fixed masked signatures and reports hit positions.
// ----------------------------------------------------------------------------
// Usage:
//   req_stream carries one byte per word plus a last_byte flag; rsp_stream
//   returns one word per position with hits: start_offset (base offset plus
//   position), a hit mask in signature order and scan_done on the final word
//   of a region. csr_* writes base_offset (index 0) and dedup_distance
//   (index 1); write them only while the scanner is idle.
//   Throughput is one byte per cycle while scanning and rsp_stream is not
//   stalled: each cycle one window position goes through the shared matcher
//   and the dedup state. A result for a window is valid once the byte that
//   completes it has passed the input register and the match has been
//   captured in the result register. On last_byte the window is flushed
//   one position per cycle while rsp_stream is not stalled, testing every
//   pending position (one to ten); one further byte may be accepted
//   meanwhile and waits. Reset returns the window, position and dedup state
//   to empty and the registers to their defaults; there is no clearing pass.
//   A stalled rsp_stream holds its word; at most one more byte is taken into
//   the input register and then req_stream.ready drops until the stall clears.
// ----------------------------------------------------------------------------
module masked_signature_byte_scanner import msbs_pkg::*; #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   msbs_req_if.sink              req_stream,
   msbs_rsp_if.source            rsp_stream
);

   // input register
   logic         in_valid_ff;
   byte_val_type in_byte_ff;
   logic         in_last_ff;

   // scan state
   seq_state_type          state_ff, state_in;
   window_type             win_ff, win_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   // configuration
   logic [OFFSET_W-1:0] base_ff;
   logic [DIST_W-1:0]   dist_ff;

   // result register
   logic                rsp_valid_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   hit_type             rsp_mask_ff;
   logic                rsp_done_ff;

   logic                   out_free;
   logic                   take;
   logic                   final_pos;
   logic                   emit;
   window_type             win_view;
   window_type             test_win;
   logic [FILL_W-1:0]      test_avail;
   hit_type                raw_hits;
   hit_type                kept_hits;
   dedup_ctrl_type         dedup_ctrl;
   logic [OFFSET_BITS-1:0] offset_sum;

   // result slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_stream.ready;

   assign req_stream.ready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_stream.valid && req_stream.ready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_stream.valid && req_stream.ready) begin
         in_byte_ff <= req_stream.data_byte;
         in_last_ff <= req_stream.last_byte;
      end
   end

   // window with the waiting byte dropped in at the fill point
   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         win_view[i] = (FILL_W'(i) == fill_ff) ? in_byte_ff : win_ff[i];
      end
   end

   // sequencer: one position tested per cycle while the result slot is free
   always_comb begin
      state_in   = state_ff;
      win_in     = win_ff;
      fill_in    = fill_ff;
      pos_in     = pos_ff;
      take       = 1'b0;
      final_pos  = 1'b0;
      dedup_ctrl = '0;
      test_win   = win_ff;
      test_avail = fill_ff;
      case (state_ff)
         SEQ_SCAN: begin
            test_win   = win_view;
            test_avail = fill_ff + 1'b1;
            take       = in_valid_ff && out_free;
            if (take) begin
               if (in_last_ff) begin
                  // hold the window with the last byte and start the flush
                  win_in   = win_view;
                  fill_in  = fill_ff + 1'b1;
                  state_in = SEQ_FLUSH;
               end else if (fill_ff + 1'b1 == FILL_W'(WIN_LEN)) begin
                  dedup_ctrl.test = 1'b1;
                  win_in          = win_view >> 8;
                  fill_in         = FILL_W'(WIN_LEN - 1);
                  pos_in          = pos_ff + 1'b1;
               end else begin
                  win_in  = win_view;
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         SEQ_FLUSH: begin
            if (out_free) begin
               dedup_ctrl.test = 1'b1;
               final_pos       = (fill_ff == FILL_W'(1));
               if (final_pos) begin
                  // drop position, fill and dedup state for the next region
                  dedup_ctrl.clear = 1'b1;
                  fill_in          = '0;
                  pos_in           = '0;
                  state_in         = SEQ_SCAN;
               end else begin
                  win_in  = win_ff >> 8;
                  fill_in = fill_ff - 1'b1;
                  pos_in  = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = SEQ_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_SCAN;
         fill_ff  <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pos_ff   <= pos_in;
      end
   end

   // bytes at or past the fill point are never compared
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   msbs_match u_match (
      .win   (test_win),
      .avail (test_avail),
      .hits  (raw_hits)
   );

   msbs_dedup #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dedup (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dedup_ctrl),
      .position (pos_ff),
      .distance (dist_ff),
      .raw_hits (raw_hits),
      .hits     (kept_hits)
   );

   // emit on a hit, or on the final position of a region even without one
   assign emit       = dedup_ctrl.test && ((kept_hits != '0) || final_pos);
   assign offset_sum = OFFSET_BITS'(base_ff) + pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_offset_ff <= OFFSET_W'(offset_sum);
         rsp_mask_ff   <= kept_hits;
         rsp_done_ff   <= final_pos;
      end
   end

   assign rsp_stream.valid        = rsp_valid_ff;
   assign rsp_stream.start_offset = rsp_offset_ff;
   assign rsp_stream.hit_mask     = rsp_mask_ff;
   assign rsp_stream.scan_done    = rsp_done_ff;

   // configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         dist_ff <= DEDUP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_OFFSET: begin
               base_ff <= csr_write_data[OFFSET_W-1:0];
            end
            CSR_DEDUP_DISTANCE: begin
               dist_ff <= csr_write_data[DIST_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // a last byte taken from the input register always starts a flush
   a_last_starts_flush : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SCAN && take && in_last_ff) |=> (state_ff == SEQ_FLUSH))
      else $error("last byte did not start a flush");

   // while scanning the window never holds a full untested span
   a_scan_fill : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_SCAN) |-> (fill_ff < FILL_W'(WIN_LEN)))
      else $error("scan fill out of range");

   // a flush always has a pending position
   a_flush_fill : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_FLUSH) |-> (fill_ff != '0))
      else $error("flush with empty window");

   // the final position clears the scan and emits a done word
   a_final_clears : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_FLUSH && out_free && fill_ff == FILL_W'(1)) |=>
      (state_ff == SEQ_SCAN && pos_ff == '0 && fill_ff == '0 &&
       rsp_valid_ff && rsp_done_ff))
      else $error("final flush position did not clear or report");

endmodule : masked_signature_byte_scanner
`default_nettype wire

>>> src/msbs_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msbs_match
// Masked compare of all signatures against the window start.
// ----------------------------------------------------------------------------
module msbs_match import msbs_pkg::*; (
   input  window_type        win,
   input  logic [FILL_W-1:0] avail,
   output hit_type           hits
);

   always_comb begin
      logic ok;
      ok = 1'b0;
      for (int k = 0; k < SIG_COUNT; k++) begin
         // fail a signature that would run past the valid bytes
         ok = (SIG_LEN[k] <= avail);
         for (int i = 0; i < WIN_LEN; i++) begin
            if ((win[i] & SIG_MASK[k][i]) != (SIG_BYTE[k][i] & SIG_MASK[k][i])) begin
               ok = 1'b0;
            end
         end
         hits[k] = ok;
      end
   end

endmodule : msbs_match
`default_nettype wire

>>> src/msbs_dedup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msbs_dedup
// Per-signature last-report tracking and suppression of close repeats.
// ----------------------------------------------------------------------------
module msbs_dedup import msbs_pkg::*; #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dedup_ctrl_type         ctrl,
   input  logic [OFFSET_BITS-1:0] position,
   input  logic [DIST_W-1:0]      distance,
   input  hit_type                raw_hits,
   output hit_type                hits
);

   logic [OFFSET_BITS-1:0] last_ff [SIG_COUNT];
   hit_type                reported_ff;

   always_comb begin
      logic [OFFSET_BITS-1:0] gap;
      gap = '0;
      for (int k = 0; k < SIG_COUNT; k++) begin
         gap     = position - last_ff[k];
         hits[k] = raw_hits[k] &&
                   !(reported_ff[k] && (gap < OFFSET_BITS'(distance)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff <= '0;
      end else if (ctrl.clear) begin
         reported_ff <= '0;
      end else if (ctrl.test) begin
         reported_ff <= reported_ff | hits;
      end
   end

   // last position is only read once the reported bit is set
   always_ff @(posedge clock) begin
      if (ctrl.test) begin
         for (int k = 0; k < SIG_COUNT; k++) begin
            if (hits[k]) begin
               last_ff[k] <= position;
            end
         end
      end
   end

endmodule : msbs_dedup
`default_nettype wire
